[rtl/bsl4_pkg.sv]
// ----------------------------------------------------------------------------
// bsl4_pkg
// Shared widths, control word layout and microcode table of the stereo
// fourth-order IIR filter.
// ----------------------------------------------------------------------------
package bsl4_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int COEF_W     = 32;
   localparam int STATE_W    = 48;
   localparam int GAIN_W     = 48;
   localparam int HALF_W     = 24;                      // split of gain / state words
   localparam int MUL_A_W    = COEF_W + 1;
   localparam int MUL_B_W    = HALF_W + 1;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int ACC_W      = 84;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;
   localparam int PC_W       = 5;

   localparam logic [CSR_IDX_W-1:0] REG_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_A2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_A1  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_A2 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_A1 = 3'd5;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_X_GLO,
      MUL_X_GHI,
      MUL_C_LO,
      MUL_C_HI
   } mul_op_type;

   typedef enum logic [3:0] {
      ACC_HOLD,
      ACC_LOAD_P,
      ACC_ADD_PS,
      ACC_NEG_P,
      ACC_SUB_P,
      ACC_SUB_PS,
      ACC_ADD_U,
      ACC_ADD_Y
   } acc_op_type;

   typedef enum logic {
      SEQ_NEXT,
      SEQ_LOOP
   } seq_op_type;

   typedef struct packed {
      mul_op_type mul_op;
      logic [1:0] cidx;       // coefficient and matching delay word
      acc_op_type acc_op;
      logic       load_u;
      logic       load_w;
      logic       load_y;
      logic       sec;
      seq_op_type seq;
   } ctrl_word_type;

   typedef struct packed {
      ctrl_word_type uc;
      logic          step_en;
   } dp_ctrl_type;

   typedef struct packed {
      logic                      mode_highpass;
      logic [GAIN_W-1:0]         input_gain;
      logic signed [COEF_W-1:0]  first_a2;
      logic signed [COEF_W-1:0]  first_a1;
      logic signed [COEF_W-1:0]  second_a2;
      logic signed [COEF_W-1:0]  second_a1;
   } cfg_type;

   localparam ctrl_word_type UC_NOP = '{
      mul_op: MUL_NONE, cidx: 2'd0, acc_op: ACC_HOLD, load_u: 1'b0,
      load_w: 1'b0, load_y: 1'b0, sec: 1'b0, seq: SEQ_NEXT};

   // one channel's program; the last step loops to the other channel
   // products issue one step ahead of the accumulate that consumes them
   function automatic ctrl_word_type ucode(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = UC_NOP;
      case (pc)
         5'd0: begin
            w.mul_op = MUL_X_GLO;
         end
         5'd1: begin
            w.mul_op = MUL_X_GHI;
            w.acc_op = ACC_LOAD_P;
         end
         5'd2: begin
            w.mul_op = MUL_C_LO; w.cidx = 2'd0;
            w.acc_op = ACC_ADD_PS;
         end
         5'd3: begin
            w.mul_op = MUL_C_HI; w.cidx = 2'd0;
            w.acc_op = ACC_NEG_P;
            w.load_u = 1'b1;
         end
         5'd4: begin
            w.mul_op = MUL_C_LO; w.cidx = 2'd1;
            w.acc_op = ACC_SUB_PS;
         end
         5'd5: begin
            w.mul_op = MUL_C_HI; w.cidx = 2'd1;
            w.acc_op = ACC_SUB_P;
         end
         5'd6: begin
            w.acc_op = ACC_SUB_PS;
         end
         5'd7: begin
            w.acc_op = ACC_ADD_U;
         end
         5'd8: begin
            w.mul_op = MUL_C_LO; w.cidx = 2'd2;
            w.load_w = 1'b1;
         end
         5'd9: begin
            w.mul_op = MUL_C_HI; w.cidx = 2'd2;
            w.acc_op = ACC_NEG_P;
            w.load_y = 1'b1; w.sec = 1'b0;
         end
         5'd10: begin
            w.mul_op = MUL_C_LO; w.cidx = 2'd3;
            w.acc_op = ACC_SUB_PS;
         end
         5'd11: begin
            w.mul_op = MUL_C_HI; w.cidx = 2'd3;
            w.acc_op = ACC_SUB_P;
         end
         5'd12: begin
            w.acc_op = ACC_SUB_PS;
         end
         5'd13: begin
            w.acc_op = ACC_ADD_Y;
         end
         5'd14: begin
            w.load_w = 1'b1;
         end
         5'd15: begin
            w.load_y = 1'b1; w.sec = 1'b1;
         end
         5'd16: begin
            w.seq = SEQ_LOOP;
         end
         default: begin
            w = UC_NOP;
         end
      endcase
      return w;
   endfunction

   // saturate a wide signed value to a state word
   function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W:0] v);
      logic hi_same;
      hi_same = (&v[ACC_W:STATE_W-1]) | ~(|v[ACC_W:STATE_W-1]);
      if (hi_same) return v[STATE_W-1:0];
      else if (v[ACC_W]) return {1'b1, {(STATE_W-1){1'b0}}};
      else return {1'b0, {(STATE_W-1){1'b1}}};
   endfunction

endpackage

[rtl/bsl4_datapath.sv]
// ----------------------------------------------------------------------------
// bsl4_datapath
// Shared multiplier, accumulator, rounding and delay words driven by the
// microcode control word.
// ----------------------------------------------------------------------------
module bsl4_datapath import bsl4_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  dp_ctrl_type                ctrl,
   input  cfg_type                    cfg,
   input  logic signed [SAMPLE_W-1:0] x_sample,
   output logic signed [SAMPLE_W-1:0] out_word
);

   localparam logic signed [ACC_W:0] RND_U = (ACC_W+1)'(1) <<< 28;
   localparam logic signed [ACC_W:0] RND_W = (ACC_W+1)'(1) <<< 29;
   localparam logic signed [STATE_W:0] RND_O = (STATE_W+1)'(1) <<< 16;

   // active channel words d*, parked channel words p*
   logic signed [STATE_W-1:0] d0_ff, d1_ff, d2_ff, d3_ff, d0_in, d1_in, d2_in, d3_in;
   logic signed [STATE_W-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p0_in, p1_in, p2_in, p3_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [STATE_W-1:0] u_ff, u_in, w_ff, w_in, y_ff, y_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [COEF_W-1:0]  coef_sel;
   logic signed [STATE_W-1:0] dly_sel, ya_sel, yb_sel;
   logic signed [ACC_W-1:0]   p_ext, ps_ext, u_ext, y_ext;
   logic signed [ACC_W:0]     acc_x, sum_u, sum_w;
   logic signed [STATE_W+2:0] y_sum;
   logic signed [STATE_W-1:0] y_sat;
   logic signed [STATE_W:0]   o_sum, o_sh;
   logic                      swap;
   ctrl_word_type             uc;

   assign uc   = ctrl.uc;
   assign swap = ctrl.step_en && (uc.seq == SEQ_LOOP);

   always_comb begin
      case (uc.cidx)
         2'd0: begin coef_sel = cfg.first_a2;  dly_sel = d0_ff; end
         2'd1: begin coef_sel = cfg.first_a1;  dly_sel = d1_ff; end
         2'd2: begin coef_sel = cfg.second_a2; dly_sel = d2_ff; end
         default: begin coef_sel = cfg.second_a1; dly_sel = d3_ff; end
      endcase
   end

   // lower halves go in unsigned, upper state half signed
   always_comb begin
      case (uc.mul_op)
         MUL_X_GLO: begin
            mul_a = {{(MUL_A_W-SAMPLE_W){x_sample[SAMPLE_W-1]}}, x_sample};
            mul_b = {1'b0, cfg.input_gain[HALF_W-1:0]};
         end
         MUL_X_GHI: begin
            mul_a = {{(MUL_A_W-SAMPLE_W){x_sample[SAMPLE_W-1]}}, x_sample};
            mul_b = {1'b0, cfg.input_gain[GAIN_W-1:HALF_W]};
         end
         MUL_C_LO: begin
            mul_a = {coef_sel[COEF_W-1], coef_sel};
            mul_b = {1'b0, dly_sel[HALF_W-1:0]};
         end
         MUL_C_HI: begin
            mul_a = {coef_sel[COEF_W-1], coef_sel};
            mul_b = {dly_sel[STATE_W-1], dly_sel[STATE_W-1:HALF_W]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = prod_ff;
      if (ctrl.step_en && uc.mul_op != MUL_NONE) prod_in = mul_a * mul_b;
   end

   assign p_ext  = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign ps_ext = {{(ACC_W-PROD_W-HALF_W){prod_ff[PROD_W-1]}}, prod_ff, {HALF_W{1'b0}}};
   assign u_ext  = {{(ACC_W-STATE_W-30){u_ff[STATE_W-1]}}, u_ff, 30'b0};
   assign y_ext  = {{(ACC_W-STATE_W-30){y_ff[STATE_W-1]}}, y_ff, 30'b0};

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.step_en) begin
         case (uc.acc_op)
            ACC_LOAD_P: acc_in = p_ext;
            ACC_ADD_PS: acc_in = acc_ff + ps_ext;
            ACC_NEG_P:  acc_in = -p_ext;
            ACC_SUB_P:  acc_in = acc_ff - p_ext;
            ACC_SUB_PS: acc_in = acc_ff - ps_ext;
            ACC_ADD_U:  acc_in = acc_ff + u_ext;
            ACC_ADD_Y:  acc_in = acc_ff + y_ext;
            default:    acc_in = acc_ff;
         endcase
      end
   end

   // gain product sits at 69 fraction bits, feedback sum at 70
   assign acc_x = {acc_ff[ACC_W-1], acc_ff};
   assign sum_u = (acc_x + RND_U) >>> 29;
   assign sum_w = (acc_x + RND_W) >>> 30;
   assign u_in  = (ctrl.step_en && uc.load_u) ? sat_state(sum_u) : u_ff;
   assign w_in  = (ctrl.step_en && uc.load_w) ? sat_state(sum_w) : w_ff;

   // section numerator d0 +/- 2*d1 + w
   always_comb begin
      ya_sel = uc.sec ? d2_ff : d0_ff;
      yb_sel = uc.sec ? d3_ff : d1_ff;
      if (cfg.mode_highpass)
         y_sum = {{3{ya_sel[STATE_W-1]}}, ya_sel} - {{2{yb_sel[STATE_W-1]}}, yb_sel, 1'b0}
               + {{3{w_ff[STATE_W-1]}}, w_ff};
      else
         y_sum = {{3{ya_sel[STATE_W-1]}}, ya_sel} + {{2{yb_sel[STATE_W-1]}}, yb_sel, 1'b0}
               + {{3{w_ff[STATE_W-1]}}, w_ff};
      if ((&y_sum[STATE_W+2:STATE_W-1]) | ~(|y_sum[STATE_W+2:STATE_W-1]))
         y_sat = y_sum[STATE_W-1:0];
      else if (y_sum[STATE_W+2])
         y_sat = {1'b1, {(STATE_W-1){1'b0}}};
      else
         y_sat = {1'b0, {(STATE_W-1){1'b1}}};
   end
   assign y_in = (ctrl.step_en && uc.load_y) ? y_sat : y_ff;

   always_comb begin
      d0_in = d0_ff; d1_in = d1_ff; d2_in = d2_ff; d3_in = d3_ff;
      p0_in = p0_ff; p1_in = p1_ff; p2_in = p2_ff; p3_in = p3_ff;
      if (swap) begin
         d0_in = p0_ff; d1_in = p1_ff; d2_in = p2_ff; d3_in = p3_ff;
         p0_in = d0_ff; p1_in = d1_ff; p2_in = d2_ff; p3_in = d3_ff;
      end else if (ctrl.step_en && uc.load_y) begin
         if (uc.sec) begin
            d2_in = d3_ff; d3_in = w_ff;
         end else begin
            d0_in = d1_ff; d1_in = w_ff;
         end
      end
   end

   // final rescale to Q1.23 with saturation
   assign o_sum = {y_ff[STATE_W-1], y_ff} + RND_O;
   assign o_sh  = o_sum >>> 17;
   always_comb begin
      if ((&o_sh[STATE_W:SAMPLE_W-1]) | ~(|o_sh[STATE_W:SAMPLE_W-1]))
         out_word = o_sh[SAMPLE_W-1:0];
      else if (o_sh[STATE_W])
         out_word = {1'b1, {(SAMPLE_W-1){1'b0}}};
      else
         out_word = {1'b0, {(SAMPLE_W-1){1'b1}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_ff <= '0; d1_ff <= '0; d2_ff <= '0; d3_ff <= '0;
         p0_ff <= '0; p1_ff <= '0; p2_ff <= '0; p3_ff <= '0;
      end else begin
         d0_ff <= d0_in; d1_ff <= d1_in; d2_ff <= d2_in; d3_ff <= d3_in;
         p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in; p3_ff <= p3_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      u_ff    <= u_in;
      w_ff    <= w_in;
      y_ff    <= y_in;
   end

endmodule

[rtl/bessel4_low_high_pass_iir_top.sv]
// ----------------------------------------------------------------------------
// bessel4_low_high_pass_iir_top
// Stereo fourth-order IIR filter, two cascaded biquad sections per channel,
// run by a microcode sequencer over one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  req      | req_valid/req_stall | req_left_sample, req_right_sample
//  rsp      | rsp_valid/rsp_stall | rsp_left_out, rsp_right_out
//  csr      | csr_we              | csr_index, csr_wdata
//
//  A word is accepted, then a 17-step program runs once per channel. The
//  single 33x25 multiplier issues ten products per channel and
//  the accumulate/round chain sets the step count.
//  Synchronous reset clears config, delay words and the sequencer.
//  A finished result waits in the output register; the last step holds while
//  an older result is still stalled.
// ----------------------------------------------------------------------------
module bessel4_low_high_pass_iir_top import bsl4_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SAMPLE_W-1:0]  req_left_sample,
   input  logic signed [SAMPLE_W-1:0]  req_right_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [SAMPLE_W-1:0]  rsp_left_out,
   output logic signed [SAMPLE_W-1:0]  rsp_right_out,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } seq_state_type;

   seq_state_type             state_ff, state_in;
   logic [PC_W-1:0]           pc_ff, pc_in;
   logic                      chan_ff, chan_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   cfg_type                   cfg_ff, cfg_in;
   logic signed [SAMPLE_W-1:0] xl_ff, xr_ff, hold_l_ff;
   logic signed [SAMPLE_W-1:0] rsp_l_ff, rsp_r_ff;

   ctrl_word_type              uc;
   dp_ctrl_type                dp_ctrl;
   logic signed [SAMPLE_W-1:0] out_word;
   logic                       accept, running, loop_step, hold, advance, finish;

   assign accept    = req_valid && !req_stall;
   assign running   = (state_ff == ST_RUN);
   assign uc        = ucode(pc_ff);
   assign loop_step = running && (uc.seq == SEQ_LOOP);
   assign hold      = loop_step && chan_ff && rsp_valid_ff && rsp_stall;
   assign advance   = running && !hold;
   assign finish    = advance && loop_step && chan_ff;

   assign dp_ctrl.uc      = uc;
   assign dp_ctrl.step_en = advance;

   assign req_stall     = running;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_l_ff;
   assign rsp_right_out = rsp_r_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_MODE:      cfg_in.mode_highpass = csr_wdata[0];
            REG_GAIN:      cfg_in.input_gain    = csr_wdata[GAIN_W-1:0];
            REG_FIRST_A2:  cfg_in.first_a2      = csr_wdata[COEF_W-1:0];
            REG_FIRST_A1:  cfg_in.first_a1      = csr_wdata[COEF_W-1:0];
            REG_SECOND_A2: cfg_in.second_a2     = csr_wdata[COEF_W-1:0];
            REG_SECOND_A1: cfg_in.second_a1     = csr_wdata[COEF_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      chan_in      = chan_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               pc_in    = '0;
               chan_in  = 1'b0;
            end
         end
         ST_RUN: begin
            if (advance) begin
               if (uc.seq == SEQ_NEXT) begin
                  pc_in = pc_ff + PC_W'(1);
               end else if (!chan_ff) begin
                  chan_in = 1'b1;
                  pc_in   = '0;
               end else begin
                  state_in     = ST_IDLE;
                  chan_in      = 1'b0;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         chan_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         xl_ff <= req_left_sample;
         xr_ff <= req_right_sample;
      end
      if (advance && loop_step && !chan_ff) hold_l_ff <= out_word;
      if (finish) begin
         rsp_l_ff <= hold_l_ff;
         rsp_r_ff <= out_word;
      end
   end

   bsl4_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (dp_ctrl),
      .cfg      (cfg_ff),
      .x_sample (chan_ff ? xr_ff : xl_ff),
      .out_word (out_word)
   );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo fourth-order IIR filter. A directed
// script (gain zero after reset, unit impulses in both modes, saturation,
// unstable and masked coefficients, ignored register indexes) is followed by
// random words over several filter settings, each checked against a bit-exact
// fixed-point model of the biquad cascade, with random sender and receiver
// stalls in all but the last two segments.
// ----------------------------------------------------------------------------
module tb import bsl4_pkg::*; ();

   localparam int CLK_HALF          = 5;
   localparam int RESET_CYCLES      = 9;
   localparam int GAIN_FRAC         = 46;
   localparam int SAMPLE_FRAC       = SAMPLE_W - 1;
   localparam int COEF_FRAC         = COEF_W - 2;
   localparam int STATE_FRAC        = STATE_W - 8;
   localparam int IN_SHIFT          = SAMPLE_FRAC + GAIN_FRAC - STATE_FRAC;
   localparam int OUT_SHIFT         = STATE_FRAC - SAMPLE_FRAC;
   localparam int SEGMENTS          = 8;
   localparam int WORDS_PER_SEGMENT = 190;
   localparam int DRAIN_CYCLES      = 40;
   localparam int MAX_PRINTED       = 100;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_7 = 3'd7;

   localparam logic [GAIN_W-1:0]          UNITY_GAIN = 48'h4000_0000_0000;
   localparam logic signed [COEF_W-1:0]   COEF_MAX   = 32'h7FFF_FFFF;
   localparam logic signed [COEF_W-1:0]   COEF_MIN   = 32'h8000_0000;
   localparam logic signed [SAMPLE_W-1:0] S_MAX      = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] S_MIN      = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef logic signed [127:0] acc_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } stereo_type;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_SAMPLE,
      ROW_CHECK
   } row_kind_type;

   typedef struct {
      row_kind_type               kind;
      logic [CSR_IDX_W-1:0]       idx;
      logic [CSR_DATA_W-1:0]      data;
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic signed [SAMPLE_W-1:0] exp_left;
      logic signed [SAMPLE_W-1:0] exp_right;
   } script_row_type;

   logic                        clock            = 1'b0;
   logic                        reset            = 1'b1;
   logic                        req_valid        = 1'b0;
   logic                        req_stall;
   logic signed [SAMPLE_W-1:0]  req_left_sample  = '0;
   logic signed [SAMPLE_W-1:0]  req_right_sample = '0;
   logic                        rsp_valid;
   logic                        rsp_stall        = 1'b0;
   logic signed [SAMPLE_W-1:0]  rsp_left_out;
   logic signed [SAMPLE_W-1:0]  rsp_right_out;
   logic                        csr_we           = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index        = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata        = '0;

   // filter model: configuration and per-channel delay words
   cfg_type                    model_cfg;
   logic signed [STATE_W-1:0]  delay_words [2][4];
   stereo_type                 pending_out [$];

   // typed-in expectation for the word now on the request port
   logic                       fixed_valid = 1'b0;
   logic signed [SAMPLE_W-1:0] fixed_left  = '0;
   logic signed [SAMPLE_W-1:0] fixed_right = '0;

   int send_idle     = 0;
   int recv_idle     = 0;
   int error_count   = 0;
   int words_checked = 0;
   int csr_writes    = 0;

   bessel4_low_high_pass_iir_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_out     (rsp_left_out),
      .rsp_right_out    (rsp_right_out),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   // ------------------------------------------------------------------------
   // fixed-point model
   // ------------------------------------------------------------------------
   function automatic acc_type clamp(input acc_type v, input int bits);
      acc_type top;
      top = (acc_type'(1) <<< (bits - 1)) - acc_type'(1);
      if (v > top) return top;
      if (v < -top - acc_type'(1)) return -top - acc_type'(1);
      return v;
   endfunction

   // round half up, then arithmetic shift
   function automatic acc_type round_shift(input acc_type v, input int s);
      return (v + (acc_type'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic acc_type biquad_step(input int ch, input int base, input acc_type x,
                                           input logic signed [COEF_W-1:0] a2,
                                           input logic signed [COEF_W-1:0] a1);
      acc_type d0, d1, acc, w, num;
      d0  = acc_type'(delay_words[ch][base]);
      d1  = acc_type'(delay_words[ch][base+1]);
      acc = (x <<< COEF_FRAC) - acc_type'(a2) * d0 - acc_type'(a1) * d1;
      w   = clamp(round_shift(acc, COEF_FRAC), STATE_W);
      num = model_cfg.mode_highpass ? d0 - (d1 <<< 1) + w : d0 + (d1 <<< 1) + w;
      delay_words[ch][base]   = delay_words[ch][base+1];
      delay_words[ch][base+1] = w[STATE_W-1:0];
      return clamp(num, STATE_W);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] filter_channel(
         input int ch, input logic signed [SAMPLE_W-1:0] x);
      acc_type u, y, t;
      u = clamp(round_shift(acc_type'(x) * acc_type'(model_cfg.input_gain), IN_SHIFT),
                STATE_W);
      y = biquad_step(ch, 0, u, model_cfg.first_a2, model_cfg.first_a1);
      y = biquad_step(ch, 2, y, model_cfg.second_a2, model_cfg.second_a1);
      t = clamp(round_shift(y, OUT_SHIFT), SAMPLE_W);
      return t[SAMPLE_W-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------
   task automatic report_error(input string msg);
      if (error_count < MAX_PRINTED) $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   always @(posedge clock) begin : watch
      stereo_type got_exp;
      stereo_type next_exp;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_out.size() == 0) begin
               report_error($sformatf("unexpected word %0d/%0d", rsp_left_out, rsp_right_out));
            end else begin
               got_exp = pending_out.pop_front();
               if (rsp_left_out !== got_exp.left)
                  report_error($sformatf("word %0d left_out %0d, expected %0d",
                                         words_checked, rsp_left_out, got_exp.left));
               if (rsp_right_out !== got_exp.right)
                  report_error($sformatf("word %0d right_out %0d, expected %0d",
                                         words_checked, rsp_right_out, got_exp.right));
               words_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            next_exp.left  = filter_channel(0, req_left_sample);
            next_exp.right = filter_channel(1, req_right_sample);
            if (fixed_valid) begin
               next_exp.left  = fixed_left;
               next_exp.right = fixed_right;
            end
            pending_out.push_back(next_exp);
         end
      end
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(0, 99) < recv_idle);
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_left_sample  = l;
      req_right_sample = r;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      while (pending_out.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      case (idx)
         REG_MODE:      model_cfg.mode_highpass = data[0];
         REG_GAIN:      model_cfg.input_gain    = data[GAIN_W-1:0];
         REG_FIRST_A2:  model_cfg.first_a2      = data[COEF_W-1:0];
         REG_FIRST_A1:  model_cfg.first_a1      = data[COEF_W-1:0];
         REG_SECOND_A2: model_cfg.second_a2     = data[COEF_W-1:0];
         REG_SECOND_A1: model_cfg.second_a1     = data[COEF_W-1:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic script_row_type wr_row(input logic [CSR_IDX_W-1:0] idx,
                                             input logic [CSR_DATA_W-1:0] data);
      script_row_type row;
      row.kind = ROW_WRITE; row.idx = idx; row.data = data;
      row.left = '0; row.right = '0; row.exp_left = '0; row.exp_right = '0;
      return row;
   endfunction

   function automatic script_row_type in_row(input logic signed [SAMPLE_W-1:0] l,
                                             input logic signed [SAMPLE_W-1:0] r);
      script_row_type row;
      row.kind = ROW_SAMPLE; row.idx = '0; row.data = '0;
      row.left = l; row.right = r; row.exp_left = '0; row.exp_right = '0;
      return row;
   endfunction

   function automatic script_row_type chk_row(input logic signed [SAMPLE_W-1:0] l,
                                              input logic signed [SAMPLE_W-1:0] r,
                                              input logic signed [SAMPLE_W-1:0] el,
                                              input logic signed [SAMPLE_W-1:0] er);
      script_row_type row;
      row.kind = ROW_CHECK; row.idx = '0; row.data = '0;
      row.left = l; row.right = r; row.exp_left = el; row.exp_right = er;
      return row;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 9))
         0:       return r[0] ? S_MAX : S_MIN;
         1:       return {{(SAMPLE_W-8){r[7]}}, r[7:0]};
         2:       return '0;
         default: return r[SAMPLE_W-1:0];
      endcase
   endfunction

   // stable pole pair most of the time: |a2| < 1, |a1| < 1 + a2
   task automatic pick_section(output logic signed [COEF_W-1:0] a2,
                               output logic signed [COEF_W-1:0] a1);
      longint lim, v2, v1;
      logic [31:0] r;
      r = $urandom();
      if ($urandom_range(0, 9) < 3) begin
         a2 = r;
         a1 = $urandom();
      end else begin
         v2  = longint'($urandom_range(0, 32'h7FFF_FFFE)) - 64'sd1073741823;
         lim = 64'sd1073741824 + v2;
         v1  = longint'($urandom_range(0, 32'(2 * lim - 2))) - (lim - 1);
         a2  = v2[COEF_W-1:0];
         a1  = v1[COEF_W-1:0];
      end
   endtask

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : main
      script_row_type            script [$];
      logic [31:0]               r;
      logic [GAIN_W-1:0]         gain;
      logic                      mode;
      logic signed [COEF_W-1:0]  a2f, a1f, a2s, a1s;
      int                        directed;

      model_cfg = '0;
      for (int c = 0; c < 2; c++)
         for (int k = 0; k < 4; k++) delay_words[c][k] = '0;

      // gain is zero after reset
      script.push_back(chk_row(S_MAX, S_MIN, 0, 0));
      script.push_back(chk_row(S_MIN, S_MAX, 0, 0));
      // unit gain, zero poles: lowpass impulse is 1 4 6 4 1
      script.push_back(wr_row(REG_GAIN, UNITY_GAIN));
      script.push_back(chk_row(1000, -1000, 1000, -1000));
      script.push_back(chk_row(0, 0, 4000, -4000));
      script.push_back(chk_row(0, 0, 6000, -6000));
      script.push_back(chk_row(0, 0, 4000, -4000));
      script.push_back(chk_row(0, 0, 1000, -1000));
      script.push_back(chk_row(0, 0, 0, 0));
      // highpass, upper data bits must be dropped: impulse is 1 -4 6 -4 1
      script.push_back(wr_row(REG_MODE, 48'hABCD_0000_0001));
      script.push_back(chk_row(500, -500, 500, -500));
      script.push_back(chk_row(0, 0, -2000, 2000));
      script.push_back(chk_row(0, 0, 3000, -3000));
      script.push_back(chk_row(0, 0, -2000, 2000));
      script.push_back(chk_row(0, 0, 500, -500));
      // full-scale impulse, then output saturation on the -4, 6 and -4 taps
      script.push_back(chk_row(S_MAX, S_MIN, S_MAX, S_MIN));
      script.push_back(in_row(0, 0));
      script.push_back(in_row(0, 0));
      script.push_back(in_row(0, 0));
      script.push_back(in_row(0, 0));
      // max gain, lowpass, full-scale steps saturate the output
      script.push_back(wr_row(REG_MODE, 48'h0));
      script.push_back(wr_row(REG_GAIN, '1));
      script.push_back(in_row(S_MAX, S_MIN));
      script.push_back(in_row(S_MAX, S_MIN));
      script.push_back(in_row(S_MAX, S_MIN));
      // unstable poles, coefficients masked to 32 bits, spare indexes ignored
      script.push_back(wr_row(REG_FIRST_A2, 48'hFFFF_8000_0000));
      script.push_back(wr_row(REG_FIRST_A1, 48'h0000_7FFF_FFFF));
      script.push_back(wr_row(REG_SECOND_A2, 48'h5A5A_7FFF_FFFF));
      script.push_back(wr_row(REG_SECOND_A1, 48'h1234_8000_0000));
      script.push_back(wr_row(REG_SPARE_6, '1));
      script.push_back(wr_row(REG_SPARE_7, '1));
      script.push_back(in_row(1, -1));
      script.push_back(in_row(0, 0));
      script.push_back(in_row(0, 0));
      script.push_back(in_row(S_MAX, S_MIN));
      // zero gain: only the saturated state rings on
      script.push_back(wr_row(REG_GAIN, '0));
      script.push_back(in_row(0, 0));

      send_idle = 35;
      recv_idle = 88;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_WRITE) begin
            req_valid = 1'b0;
            wait_drain();
            csr_write(script[i].idx, script[i].data);
         end else begin
            fixed_valid = (script[i].kind == ROW_CHECK);
            fixed_left  = script[i].exp_left;
            fixed_right = script[i].exp_right;
            send_word(script[i].left, script[i].right);
         end
      end
      req_valid   = 1'b0;
      fixed_valid = 1'b0;
      wait_drain();
      directed = words_checked;

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < 3) begin
            send_idle = 35; recv_idle = 88;
         end else if (seg < 6) begin
            send_idle = 88; recv_idle = 35;
         end else begin
            send_idle = 0;  recv_idle = 0;
         end

         case (seg)
            0: begin
               mode = 1'b1; gain = '1;
               a2f = COEF_MAX; a1f = COEF_MAX; a2s = COEF_MAX; a1s = COEF_MAX;
            end
            1: begin
               mode = 1'b0; gain = UNITY_GAIN;
               a2f = COEF_MIN; a1f = COEF_MIN; a2s = COEF_MIN; a1s = COEF_MIN;
            end
            default: begin
               mode = 1'($urandom_range(0, 1));
               r = $urandom();
               case ($urandom_range(0, 3))
                  0:       gain = {r[15:0], $urandom()};
                  1:       gain = UNITY_GAIN + r[19:0] - 48'h8_0000;
                  2:       gain = {2'b00, r[13:0], $urandom()};
                  default: gain = '1;
               endcase
               pick_section(a2f, a1f);
               pick_section(a2s, a1s);
            end
         endcase

         wait_drain();
         r = $urandom();
         csr_write(REG_MODE, {r, r[15:1], mode});
         csr_write(REG_GAIN, gain);
         r = $urandom();
         csr_write(REG_FIRST_A2, {r[15:0], a2f});
         csr_write(REG_FIRST_A1, {r[31:16], a1f});
         r = $urandom();
         csr_write(REG_SECOND_A2, {r[15:0], a2s});
         csr_write(REG_SECOND_A1, {r[31:16], a1s});
         csr_write(r[0] ? REG_SPARE_6 : REG_SPARE_7, {r[15:0], $urandom()});

         for (int n = 0; n < WORDS_PER_SEGMENT; n++)
            send_word(random_sample(), random_sample());
         req_valid = 1'b0;
      end

      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d stereo words (%0d directed) over %0d register writes,",
               words_checked, directed, csr_writes);
      $display("lowpass and highpass, stable and saturating poles, with random stalls.");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("TIMEOUT: %0d words still expected", pending_out.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
